// ===== hdl/pfs_pkg.sv =====
// Package for the priority bucket task scheduler: command, state and status codes,
// the request and result payloads and the task state entry.
// No dependencies.
`default_nettype none

package pfs_pkg;

  // Commands carried in a request
  typedef enum logic [2:0] {
    CMD_ENQ    = 3'd0,
    CMD_DEQ    = 3'd1,
    CMD_PICK   = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_SET    = 3'd4,
    CMD_REPRIO = 3'd5
  } cmd_e;

  // Task run states (codes five to seven are stored as given and act as blocked)
  localparam logic [2:0] ST_READY     = 3'd0;
  localparam logic [2:0] ST_RUNNING   = 3'd1;
  localparam logic [2:0] ST_SLEEPING  = 3'd2;
  localparam logic [2:0] ST_SUSPENDED = 3'd3;
  localparam logic [2:0] ST_BLOCKED   = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_NONE     = 2'd2;

  // CPU field code for a task that may run anywhere
  localparam logic [4:0] CPU_ANY = 5'd16;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  task_id;
    logic [7:0]  priority_req;
    logic [2:0]  task_state;
    logic [31:0] wake_tick;
    logic        cpu_any;
    logic [3:0]  cpu_affinity;
    logic        current_valid;
    logic [7:0]  current_priority;
    logic [3:0]  this_cpu;
    logic [31:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       need_resched;
    logic       picked_valid;
    logic [5:0] picked_task;
  } res_t;

  // Per-task scheduling state held in one memory word
  typedef struct packed {
    logic [2:0]  run_state;
    logic [31:0] wake;
    logic [4:0]  cpu;
  } st_entry_t;

  // Verdict on one visited list node
  typedef struct packed {
    logic woke;
    logic hit;
  } node_eval_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_CHK,
    S_RM_START,
    S_RM_HEAD,
    S_RM_WALK,
    S_RM_END,
    S_AP_WR,
    S_AP_LINK,
    S_SCAN_HEAD,
    S_SCAN_NODE,
    S_DONE
  } fsm_t;

endpackage

`default_nettype wire

// ===== hdl/pfs_req_if.sv =====
// Request channel of the task scheduler: valid/ready handshake with a req_t payload.
// Depends on pfs_pkg.
`default_nettype none

interface pfs_req_if;
  import pfs_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pfs_res_if.sv =====
// Result channel of the task scheduler: valid/ready handshake with a res_t payload.
// Depends on pfs_pkg.
`default_nettype none

interface pfs_res_if;
  import pfs_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pfs_node_eval.sv =====
// Node check for the bucket scans: wrapped wake test, affinity match and hit decision.
// Depends on pfs_pkg.
`default_nettype none

module pfs_node_eval (
  input  logic                 is_pick,
  input  pfs_pkg::st_entry_t   ent,
  input  logic [31:0]          now_ticks,
  input  logic [3:0]           this_cpu,
  output pfs_pkg::node_eval_t  verdict
);
  import pfs_pkg::*;

  logic [31:0] since_wake;
  logic [2:0]  eff_state;
  logic        cpu_ok;

  // Sleeper wakes when now - wake is non-negative in wrapped arithmetic
  assign since_wake = now_ticks - ent.wake;

  always_comb begin
    verdict.woke = is_pick && (ent.run_state == ST_SLEEPING) && !since_wake[31];
    eff_state    = verdict.woke ? ST_READY : ent.run_state;
    cpu_ok       = (ent.cpu == CPU_ANY) || (ent.cpu == {1'b0, this_cpu});
    // Tick only looks for a ready task; pick also honors affinity
    verdict.hit  = (eff_state == ST_READY) && (cpu_ok || !is_pick);
  end

endmodule

`default_nettype wire

// ===== hdl/priority_fifo_task_scheduler.sv =====
// Priority bucket FIFO ready-queue scheduler, top level.
// Depends on pfs_pkg, pfs_req_if, pfs_res_if and pfs_node_eval.
//
// Usage: one request enters on req (valid/ready), one result leaves on res
// (valid/ready). Commands: enqueue, dequeue, pick next, tick, set task state,
// reprioritize. The task table and the bucket head/tail pointers live in
// synchronous memories; each command is a short read-modify-write
// sequence driven by one state machine, one request at a time.
// Dequeue and reprioritize walk the old bucket list to the task when it is queued;
// pick and tick visit buckets from the top down and the tasks in each; a pick over
// an empty table visits all NUM_PRIOS buckets. The bucket and task memories each
// have a single read port, so buckets and list nodes are read one at a time.
// After reset a clearing pass writes the reset values into both memories,
// one entry per cycle through max(MAX_TASKS, NUM_PRIOS) entries (256 by default);
// req.ready stays low during it.
// The result sits in an output register; the next request is accepted while it
// waits, but a finished command holds until res.ready frees the register.
`default_nettype none

module priority_fifo_task_scheduler #(
  parameter int MAX_TASKS = 64,
  parameter int NUM_PRIOS = 256
) (
  input  logic       clk,
  input  logic       rst,
  pfs_req_if.sink    req,
  pfs_res_if.source  res
);
  import pfs_pkg::*;

  localparam int TW    = $clog2(MAX_TASKS);
  localparam int LW    = $clog2(MAX_TASKS + 1);
  localparam int PW    = $clog2(NUM_PRIOS);
  localparam int CLR_N = (MAX_TASKS > NUM_PRIOS) ? MAX_TASKS : NUM_PRIOS;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [LW-1:0] NIL = LW'(MAX_TASKS);
  localparam logic [PW-1:0] TOP = PW'(NUM_PRIOS - 1);

  // Memories
  logic [2*LW-1:0] bkt_mem  [NUM_PRIOS];
  logic [LW-1:0]   link_mem [MAX_TASKS];
  logic [PW:0]     qp_mem   [MAX_TASKS];
  st_entry_t       st_mem   [MAX_TASKS];

  logic            bkt_we, bkt_re;
  logic [PW-1:0]   bkt_waddr, bkt_raddr;
  logic [2*LW-1:0] bkt_wdata, bkt_rdata;
  logic            task_re;
  logic [TW-1:0]   task_raddr;
  logic            link_we;
  logic [TW-1:0]   link_waddr;
  logic [LW-1:0]   link_wdata, link_rdata;
  logic            qp_we;
  logic [TW-1:0]   qp_waddr;
  logic [PW:0]     qp_wdata, qp_rdata;
  logic            st_we;
  logic [TW-1:0]   st_waddr;
  st_entry_t       st_wdata, st_rdata;

  // Control and working registers
  fsm_t          state, state_next;
  logic [CW-1:0] clr_idx;
  req_t          rq;
  logic [PW-1:0] p, p_next;
  logic [PW-1:0] oldp, oldp_next;
  logic [LW-1:0] cur, cur_next;
  logic [LW-1:0] prev, prev_next;
  res_t          rslt, rslt_next;
  res_t          res_q;
  logic          res_v;

  // Derived values
  logic [TW-1:0] t_idx;
  logic [LW-1:0] t_lnk;
  logic          id_ok;
  logic [PW-1:0] pn;
  logic [LW-1:0] bkt_head, bkt_tail;
  logic          head_nil, link_nil;
  logic          qp_queued;
  logic [PW-1:0] qp_prio;
  logic          is_pick;
  logic          scan_last;
  logic          tick_any;
  logic          preempt;
  logic          clr_last;
  logic          out_free;
  node_eval_t    verdict;

  assign t_idx     = TW'(rq.task_id);
  assign t_lnk     = LW'(rq.task_id);
  assign id_ok     = {5'b0, rq.task_id} < 11'(MAX_TASKS);
  assign pn        = ({1'b0, rq.priority_req} >= 9'(NUM_PRIOS)) ? TOP : PW'(rq.priority_req);
  assign bkt_head  = bkt_rdata[2*LW-1:LW];
  assign bkt_tail  = bkt_rdata[LW-1:0];
  assign head_nil  = (bkt_head == NIL);
  assign link_nil  = (link_rdata == NIL);
  assign qp_queued = qp_rdata[PW];
  assign qp_prio   = qp_rdata[PW-1:0];
  assign is_pick   = (rq.command == CMD_PICK);
  assign tick_any  = 8'(TOP) > rq.current_priority;
  assign preempt   = rq.current_valid && (st_rdata.run_state == ST_READY) &&
                     (8'(pn) > rq.current_priority);
  assign clr_last  = (clr_idx == CW'(CLR_N - 1));
  assign out_free  = !res_v || res.ready;

  // Last bucket of a scan: bucket 0 for pick, the one just above current for tick
  assign scan_last = is_pick ? (p == '0)
                             : ({1'b0, 8'(p)} <= ({1'b0, rq.current_priority} + 9'd1));

  pfs_node_eval u_eval (
    .is_pick   (is_pick),
    .ent       (st_rdata),
    .now_ticks (rq.now_ticks),
    .this_cpu  (rq.this_cpu),
    .verdict   (verdict)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (req.valid) state_next = S_START;
      S_START: begin
        case (rq.command)
          CMD_ENQ, CMD_DEQ, CMD_REPRIO: state_next = id_ok ? S_CHK : S_DONE;
          CMD_PICK: state_next = S_SCAN_HEAD;
          CMD_TICK: state_next = (rq.current_valid && tick_any) ? S_SCAN_HEAD : S_DONE;
          default:  state_next = S_DONE;
        endcase
      end
      S_CHK: begin
        if (!qp_queued) begin
          state_next = (rq.command == CMD_ENQ) ? S_AP_WR : S_DONE;
        end else begin
          state_next = (rq.command == CMD_ENQ) ? S_DONE : S_RM_START;
        end
      end
      S_RM_START: state_next = S_RM_HEAD;
      S_RM_HEAD:  state_next = head_nil ? S_RM_END : S_RM_WALK;
      S_RM_WALK:  if (cur == t_lnk || link_nil) state_next = S_RM_END;
      S_RM_END:   state_next = (rq.command == CMD_REPRIO) ? S_AP_WR : S_DONE;
      S_AP_WR:    state_next = head_nil ? S_DONE : S_AP_LINK;
      S_AP_LINK:  state_next = S_DONE;
      S_SCAN_HEAD: begin
        if (!head_nil) state_next = S_SCAN_NODE;
        else if (scan_last) state_next = S_DONE;
      end
      S_SCAN_NODE: begin
        if (verdict.hit) state_next = S_DONE;
        else if (link_nil) state_next = scan_last ? S_DONE : S_SCAN_HEAD;
      end
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls and working register updates
  always_comb begin
    bkt_we     = 1'b0;
    bkt_waddr  = p;
    bkt_wdata  = {NIL, NIL};
    bkt_re     = 1'b0;
    bkt_raddr  = p;
    task_re    = 1'b0;
    task_raddr = t_idx;
    link_we    = 1'b0;
    link_waddr = t_idx;
    link_wdata = NIL;
    qp_we      = 1'b0;
    qp_waddr   = t_idx;
    qp_wdata   = '0;
    st_we      = 1'b0;
    st_waddr   = t_idx;
    st_wdata   = st_rdata;
    p_next     = p;
    oldp_next  = oldp;
    cur_next   = cur;
    prev_next  = prev;
    rslt_next  = rslt;

    unique case (state)
      // Reset values into both memories, one entry per cycle
      S_CLEAR: begin
        bkt_we    = {1'b0, clr_idx} < (CW+1)'(NUM_PRIOS);
        bkt_waddr = clr_idx[PW-1:0];
        qp_we     = {1'b0, clr_idx} < (CW+1)'(MAX_TASKS);
        qp_waddr  = clr_idx[TW-1:0];
        st_we     = qp_we;
        st_waddr  = clr_idx[TW-1:0];
        st_wdata  = '{run_state: ST_BLOCKED, wake: 32'd0, cpu: CPU_ANY};
      end
      S_IDLE: ;
      // Issue the first reads of each command; set writes the task state directly
      S_START: begin
        rslt_next = '0;
        case (rq.command)
          CMD_ENQ: begin
            if (id_ok) begin
              task_re   = 1'b1;
              bkt_re    = 1'b1;
              bkt_raddr = pn;
            end else begin
              rslt_next.status = STATUS_NOTFOUND;
            end
          end
          CMD_DEQ, CMD_REPRIO: begin
            if (id_ok) task_re = 1'b1;
            else rslt_next.status = STATUS_NOTFOUND;
          end
          CMD_PICK: begin
            bkt_re    = 1'b1;
            bkt_raddr = TOP;
            p_next    = TOP;
          end
          CMD_TICK: begin
            if (rq.current_valid && tick_any) begin
              bkt_re    = 1'b1;
              bkt_raddr = TOP;
              p_next    = TOP;
            end
          end
          CMD_SET: begin
            if (id_ok) begin
              st_we    = 1'b1;
              st_wdata = '{run_state: rq.task_state, wake: rq.wake_tick,
                           cpu: rq.cpu_any ? CPU_ANY : {1'b0, rq.cpu_affinity}};
            end else begin
              rslt_next.status = STATUS_NOTFOUND;
            end
          end
          default: ;
        endcase
      end
      // Queued check
      S_CHK: begin
        oldp_next = qp_prio;
        if (rq.command == CMD_ENQ) begin
          if (qp_queued) rslt_next.status = STATUS_NOTFOUND;
        end else if (!qp_queued) begin
          if (rq.command == CMD_REPRIO) begin
            qp_we    = 1'b1;
            qp_wdata = {1'b0, pn};
          end else begin
            rslt_next.status = STATUS_NOTFOUND;
          end
        end
      end
      // Unlink: fetch the old bucket, then walk to the task
      S_RM_START: begin
        bkt_re    = 1'b1;
        bkt_raddr = oldp;
      end
      S_RM_HEAD: begin
        cur_next   = bkt_head;
        prev_next  = NIL;
        task_re    = !head_nil;
        task_raddr = bkt_head[TW-1:0];
      end
      S_RM_WALK: begin
        if (cur == t_lnk) begin
          bkt_we    = 1'b1;
          bkt_waddr = oldp;
          bkt_wdata = {(prev == NIL) ? link_rdata : bkt_head,
                       (bkt_tail == t_lnk) ? prev : bkt_tail};
          link_we    = (prev != NIL);
          link_waddr = prev[TW-1:0];
          link_wdata = link_rdata;
        end else if (!link_nil) begin
          prev_next  = cur;
          cur_next   = link_rdata;
          task_re    = 1'b1;
          task_raddr = link_rdata[TW-1:0];
        end
      end
      S_RM_END: begin
        qp_we    = 1'b1;
        qp_wdata = {1'b0, oldp};
        if (rq.command == CMD_REPRIO) begin
          task_re   = 1'b1;
          bkt_re    = 1'b1;
          bkt_raddr = pn;
        end
      end
      // Append at the tail of the new bucket
      S_AP_WR: begin
        qp_we     = 1'b1;
        qp_wdata  = {1'b1, pn};
        link_we   = 1'b1;
        bkt_we    = 1'b1;
        bkt_waddr = pn;
        bkt_wdata = head_nil ? {t_lnk, t_lnk} : {bkt_head, t_lnk};
        rslt_next.need_resched = preempt;
      end
      S_AP_LINK: begin
        link_we    = 1'b1;
        link_waddr = bkt_tail[TW-1:0];
        link_wdata = t_lnk;
      end
      // Bucket scan, high to low
      S_SCAN_HEAD: begin
        if (!head_nil) begin
          cur_next   = bkt_head;
          task_re    = 1'b1;
          task_raddr = bkt_head[TW-1:0];
        end else if (scan_last) begin
          rslt_next.status = is_pick ? STATUS_NONE : STATUS_OK;
        end else begin
          p_next    = p - PW'(1);
          bkt_re    = 1'b1;
          bkt_raddr = p - PW'(1);
        end
      end
      S_SCAN_NODE: begin
        st_waddr = cur[TW-1:0];
        if (verdict.hit) begin
          if (is_pick) begin
            st_we                  = 1'b1;
            st_wdata.run_state     = ST_RUNNING;
            rslt_next.picked_valid = 1'b1;
            rslt_next.picked_task  = 6'(cur);
          end else begin
            rslt_next.need_resched = 1'b1;
          end
        end else begin
          if (verdict.woke) begin
            st_we              = 1'b1;
            st_wdata.run_state = ST_READY;
          end
          if (!link_nil) begin
            cur_next   = link_rdata;
            task_re    = 1'b1;
            task_raddr = link_rdata[TW-1:0];
          end else if (scan_last) begin
            rslt_next.status = is_pick ? STATUS_NONE : STATUS_OK;
          end else begin
            p_next    = p - PW'(1);
            bkt_re    = 1'b1;
            bkt_raddr = p - PW'(1);
          end
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Memory arrays
  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
    if (bkt_re) bkt_rdata <= bkt_mem[bkt_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (qp_we) qp_mem[qp_waddr] <= qp_wdata;
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (task_re) begin
      link_rdata <= link_mem[task_raddr];
      qp_rdata   <= qp_mem[task_raddr];
      st_rdata   <= st_mem[task_raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      res_v   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + CW'(1);
      if (state == S_DONE && out_free) res_v <= 1'b1;
      else if (res.ready) res_v <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) rq <= req.data;
    p    <= p_next;
    oldp <= oldp_next;
    cur  <= cur_next;
    prev <= prev_next;
    rslt <= rslt_next;
    if (state == S_DONE && out_free) res_q <= rslt;
  end

  assign req.ready = (state == S_IDLE);
  assign res.valid = res_v;
  assign res.data  = res_q;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_START))
    else $error("accepted request did not start a command");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !res.valid)
    else $error("result offered during clearing pass");

  a_pick_status: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.picked_valid) |-> (res.data.status == STATUS_OK))
    else $error("picked task with nonzero status");

  a_scan_no_bucket_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_HEAD || state == S_SCAN_NODE) |-> !bkt_we)
    else $error("bucket written during scan");

  a_node_not_nil: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_NODE || state == S_RM_WALK) |-> (cur != NIL))
    else $error("walking a null link");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the priority bucket task scheduler: drives requests, predicts each
// result with its own scheduler model, and checks results in order.
// Depends on pfs_pkg, pfs_req_if, pfs_res_if and priority_fifo_task_scheduler.
`default_nettype none

module tb_top;
  import pfs_pkg::*;

  localparam int NTASK = 64;
  localparam int NPRIO = 256;
  localparam int NIL = NTASK;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfs_req_if req_ch ();
  pfs_res_if res_ch ();

  priority_fifo_task_scheduler u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .res(res_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scheduler state mirror
  int          head_q [NPRIO];
  int          tail_q [NPRIO];
  int          link_q [NTASK];
  logic [7:0]  prio_m [NTASK];
  logic [2:0]  run_m [NTASK];
  logic [31:0] wake_m [NTASK];
  logic [4:0]  cpu_m [NTASK];
  bit          queued_m [NTASK];

  res_t   sched_results [$];
  int     error_count = 0;
  longint cycle_count = 0;
  bit     hold_off = 1'b0;
  bit     no_gaps = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void mirror_reset();
    for (int i = 0; i < NPRIO; i++) begin
      head_q[i] = NIL;
      tail_q[i] = NIL;
    end
    for (int i = 0; i < NTASK; i++) begin
      link_q[i] = NIL;
      prio_m[i] = '0;
      run_m[i] = ST_BLOCKED;
      wake_m[i] = '0;
      cpu_m[i] = CPU_ANY;
      queued_m[i] = 1'b0;
    end
  endfunction

  function automatic void bucket_append(input int t);
    int p;
    p = prio_m[t];
    link_q[t] = NIL;
    if (head_q[p] == NIL) head_q[p] = t;
    else link_q[tail_q[p]] = t;
    tail_q[p] = t;
    queued_m[t] = 1'b1;
  endfunction

  function automatic void bucket_unlink(input int t);
    int p, prev, cur;
    p = prio_m[t];
    prev = NIL;
    cur = head_q[p];
    while (cur != NIL) begin
      if (cur == t) begin
        if (prev == NIL) head_q[p] = link_q[t];
        else link_q[prev] = link_q[t];
        if (tail_q[p] == t) tail_q[p] = prev;
        break;
      end
      prev = cur;
      cur = link_q[cur];
    end
    link_q[t] = NIL;
    queued_m[t] = 1'b0;
  endfunction

  function automatic bit outranks(input int t, input req_t r);
    return r.current_valid && run_m[t] == ST_READY && prio_m[t] > r.current_priority;
  endfunction

  // Compute the result of one request and update the mirror
  function automatic res_t schedule_step(input req_t r);
    res_t o;
    int t, cur;
    bit found;
    o = '0;
    t = r.task_id;
    case (r.command)
      CMD_ENQ: begin
        if (queued_m[t]) o.status = STATUS_NOTFOUND;
        else begin
          prio_m[t] = r.priority_req;
          bucket_append(t);
          o.need_resched = outranks(t, r);
        end
      end
      CMD_DEQ: begin
        if (!queued_m[t]) o.status = STATUS_NOTFOUND;
        else bucket_unlink(t);
      end
      CMD_PICK: begin
        found = 1'b0;
        for (int p = NPRIO - 1; p >= 0 && !found; p--) begin
          cur = head_q[p];
          while (cur != NIL) begin
            if (run_m[cur] == ST_SLEEPING && !((r.now_ticks - wake_m[cur]) >> 31))
              run_m[cur] = ST_READY;
            if (run_m[cur] == ST_READY &&
                (cpu_m[cur] == CPU_ANY || cpu_m[cur] == {1'b0, r.this_cpu})) begin
              run_m[cur] = ST_RUNNING;
              o.picked_valid = 1'b1;
              o.picked_task = 6'(cur);
              found = 1'b1;
              break;
            end
            cur = link_q[cur];
          end
        end
        if (!found) o.status = STATUS_NONE;
      end
      CMD_TICK: begin
        if (r.current_valid) begin
          for (int p = NPRIO - 1; p > int'(r.current_priority) && !o.need_resched; p--) begin
            cur = head_q[p];
            while (cur != NIL) begin
              if (run_m[cur] == ST_READY) begin
                o.need_resched = 1'b1;
                break;
              end
              cur = link_q[cur];
            end
          end
        end
      end
      CMD_SET: begin
        run_m[t] = r.task_state;
        wake_m[t] = r.wake_tick;
        cpu_m[t] = r.cpu_any ? CPU_ANY : {1'b0, r.cpu_affinity};
      end
      CMD_REPRIO: begin
        if (queued_m[t]) begin
          bucket_unlink(t);
          prio_m[t] = r.priority_req;
          bucket_append(t);
          o.need_resched = outranks(t, r);
        end else prio_m[t] = r.priority_req;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r = '0;
    r.command = $urandom_range(0, 99) < 2 ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(CMD_ENQ, CMD_REPRIO));
    r.task_id = $urandom_range(0, 99) < 70 ? 6'($urandom_range(0, 11)) : 6'($urandom);
    r.priority_req = $urandom_range(0, 99) < 60 ? 8'($urandom_range(0, 7)) : 8'($urandom);
    r.task_state = $urandom_range(0, 99) < 85 ? 3'($urandom_range(0, 4)) : 3'($urandom);
    r.wake_tick = $urandom;
    r.cpu_any = 1'($urandom_range(0, 1));
    r.cpu_affinity = 4'($urandom_range(0, 3));
    r.current_valid = 1'($urandom_range(0, 1));
    r.current_priority = $urandom_range(0, 99) < 60 ? 8'($urandom_range(0, 7)) : 8'($urandom);
    r.this_cpu = 4'($urandom_range(0, 3));
    r.now_ticks = $urandom;
    if ($urandom_range(0, 3) == 0) r.cpu_affinity = 4'($urandom);
    if ($urandom_range(0, 3) == 0) r.this_cpu = 4'($urandom);
    return r;
  endfunction

  // Send one request, predicting at acceptance; valid drops only on an idle cycle
  task automatic send_request(input req_t r);
    while (!no_gaps && $urandom_range(0, 99) < 8) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sched_results.push_back(schedule_step(r));
  endtask

  function automatic req_t make_req(input cmd_e c, input int id, input int pr);
    req_t r;
    r = '0;
    r.command = c;
    r.task_id = 6'(id);
    r.priority_req = 8'(pr);
    r.cpu_any = 1'b1;
    return r;
  endfunction

  // Directed: field extremes, each command and the corner cases
  task automatic test_directed();
    req_t r;
    send_request(make_req(CMD_PICK, 0, 0));
    r = make_req(CMD_SET, 63, 0);
    r.task_state = ST_READY;
    send_request(r);
    r = make_req(CMD_ENQ, 63, 255);
    r.current_valid = 1'b1;
    r.current_priority = 8'd254;
    send_request(r);
    send_request(make_req(CMD_ENQ, 63, 3));
    r = make_req(CMD_TICK, 0, 0);
    r.current_valid = 1'b1;
    r.current_priority = 8'd254;
    send_request(r);
    r.current_valid = 1'b0;
    send_request(r);
    r = make_req(CMD_SET, 0, 0);
    r.task_state = ST_SLEEPING;
    r.wake_tick = 32'hffff_fff0;
    r.cpu_any = 1'b0;
    r.cpu_affinity = 4'hf;
    send_request(r);
    send_request(make_req(CMD_ENQ, 0, 255));
    r = make_req(CMD_PICK, 0, 0);
    r.this_cpu = 4'hf;
    r.now_ticks = 32'h0000_0005;
    send_request(r);
    r = make_req(CMD_SET, 1, 0);
    r.task_state = ST_SUSPENDED;
    send_request(r);
    send_request(make_req(CMD_ENQ, 1, 0));
    r = make_req(CMD_SET, 2, 0);
    r.task_state = 3'd7;
    r.wake_tick = '1;
    send_request(r);
    send_request(make_req(CMD_ENQ, 2, 0));
    send_request(make_req(CMD_PICK, 0, 0));
    r = make_req(CMD_REPRIO, 63, 255);
    r.current_valid = 1'b1;
    send_request(r);
    send_request(make_req(CMD_REPRIO, 5, 77));
    send_request(make_req(CMD_DEQ, 5, 0));
    send_request(make_req(CMD_DEQ, 63, 0));
    send_request(make_req(CMD_DEQ, 1, 0));
    r = make_req(CMD_SET, 0, 0);
    r.command = 3'd6;
    send_request(r);
    r.command = 3'd7;
    send_request(r);
    send_request(make_req(CMD_PICK, 0, 0));
  endtask

  // Random mix biased to a few tasks and low buckets so lists grow long
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_request(random_req());
  endtask

  // Result side stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(40);
    join
  endtask

  task automatic test_no_gaps();
    no_gaps = 1'b1;
    test_random(200);
    no_gaps = 1'b0;
  endtask

  // Result ready, randomly stalled
  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= !hold_off && (no_gaps || $urandom_range(0, 99) >= 8);
  end

  // Result checker
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (sched_results.size() == 0) report("result with no request pending");
      else begin
        exp_r = sched_results.pop_front();
        if (res_ch.data.status !== exp_r.status)
          report($sformatf("status %0d, want %0d", res_ch.data.status, exp_r.status));
        if (res_ch.data.need_resched !== exp_r.need_resched)
          report($sformatf("need_resched %0b, want %0b", res_ch.data.need_resched,
                           exp_r.need_resched));
        if (res_ch.data.picked_valid !== exp_r.picked_valid)
          report($sformatf("picked_valid %0b, want %0b", res_ch.data.picked_valid,
                           exp_r.picked_valid));
        if (res_ch.data.picked_task !== exp_r.picked_task)
          report($sformatf("picked_task %0d, want %0d", res_ch.data.picked_task,
                           exp_r.picked_task));
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    mirror_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(600);
    test_backpressure();
    test_no_gaps();
    test_random(640);
    req_ch.valid <= 1'b0;
    while (sched_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (error_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/pfs_pkg.sv
hdl/pfs_req_if.sv
hdl/pfs_res_if.sv
hdl/pfs_node_eval.sv
hdl/priority_fifo_task_scheduler.sv
dv/tb_top.sv
